### rtl/sst_pkg.sv
// Shared types and codes for the sorted set table.
// Command and status codes, controller states and the control/status structs.
// Used by sst_ctrl, sst_dpath and sorted_set_table; depends on nothing.
`default_nettype none

package sst_pkg;

  localparam int DEPTH_DEF      = 256;
  localparam int VALUE_BITS_DEF = 32;
  localparam int CMD_W          = 3;
  localparam int STAT_W         = 2;

  localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_INS_AT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DEL_AT = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;

  localparam logic [STAT_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STAT_W-1:0] ST_ABSENT = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd3;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INS,
    OP_DEL
  } op_kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_RESOLVE,
    S_UP_RD,
    S_UP_WR,
    S_PUT,
    S_DN_RD,
    S_DN_WR,
    S_FETCH,
    S_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic srch_step;
    logic srch_cmp;
    logic resolve;
    logic up_step;
    logic up_write;
    logic put;
    logic dn_step;
    logic dn_write;
    logic fetch;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic     is_search;
    logic     srch_more;
    logic     srch_eq;
    op_kind_t op;
    logic     up_more;
    logic     dn_more;
    logic     out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

### rtl/sst_ctrl.sv
// Controller state machine of the sorted set table.
// Sequences search probes, entry shifts, the result fetch and the output load.
// Depends on sst_pkg.
`default_nettype none

module sst_ctrl
  import sst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = stat.is_search ? S_SRCH_RD : S_RESOLVE;
      end
      S_SRCH_RD: begin
        cmd.srch_step = 1'b1;
        state_nxt     = stat.srch_more ? S_SRCH_CMP : S_RESOLVE;
      end
      S_SRCH_CMP: begin
        cmd.srch_cmp = 1'b1;
        state_nxt    = stat.srch_eq ? S_RESOLVE : S_SRCH_RD;
      end
      S_RESOLVE: begin
        cmd.resolve = 1'b1;
        case (stat.op)
          OP_INS:  state_nxt = S_UP_RD;
          OP_DEL:  state_nxt = S_DN_RD;
          default: state_nxt = S_FETCH;
        endcase
      end
      S_UP_RD: begin
        cmd.up_step = 1'b1;
        state_nxt   = stat.up_more ? S_UP_WR : S_PUT;
      end
      S_UP_WR: begin
        cmd.up_write = 1'b1;
        state_nxt    = S_UP_RD;
      end
      S_PUT: begin
        cmd.put   = 1'b1;
        state_nxt = S_FETCH;
      end
      S_DN_RD: begin
        cmd.dn_step = 1'b1;
        state_nxt   = stat.dn_more ? S_DN_WR : S_FETCH;
      end
      S_DN_WR: begin
        cmd.dn_write = 1'b1;
        state_nxt    = S_DN_RD;
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/sst_dpath.sv
// Datapath of the sorted set table: entry memory, fill count, binary search
// registers, shift pointer and the output register.
// Depends on sst_pkg; driven by sst_ctrl.
`default_nettype none

module sst_dpath
  import sst_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  localparam int AW        = $clog2(DEPTH),
  localparam int CW        = $clog2(DEPTH + 1),
  localparam int RW        = AW + 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctrl_cmd_t             cmd,
  output dp_stat_t              stat,
  input  logic [CMD_W-1:0]      in_cmd,
  input  logic [VALUE_BITS-1:0] in_key_value,
  input  logic [CW-1:0]         in_position,
  input  logic                  out_tready,
  output logic                  out_tvalid,
  output logic [RW-1:0]         out_result_index,
  output logic [STAT_W-1:0]     out_status,
  output logic [VALUE_BITS-1:0] out_entry_at_index,
  output logic [CW-1:0]         out_fill_count
);

  // Search bounds need one bit beyond the count to hold -1.
  localparam int SW = CW + 1;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [VALUE_BITS-1:0] mem_r [DEPTH];
  logic [VALUE_BITS-1:0] rd_data_r;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [VALUE_BITS-1:0] wr_data;

  logic [CMD_W-1:0]      cmd_r;
  logic [VALUE_BITS-1:0] key_r;
  logic [CW-1:0]         pos_r;
  logic [CW-1:0]         count_r;
  logic signed [SW-1:0]  s_r;
  logic signed [SW-1:0]  e_r;
  logic signed [SW-1:0]  q_r;
  logic [AW-1:0]         p_r;
  logic                  hit_r;
  logic signed [SW-1:0]  idx_r;
  logic [STAT_W-1:0]     stat_r;
  logic [AW-1:0]         t_r;
  logic [AW-1:0]         ptr_r;
  logic                  fetch_ok_r;

  logic                  out_valid_r;
  logic [RW-1:0]         out_idx_r;
  logic [STAT_W-1:0]     out_stat_r;
  logic [VALUE_BITS-1:0] out_entry_r;
  logic [CW-1:0]         out_fill_r;

  logic signed [SW:0]    sum;
  logic [AW-1:0]         p;
  logic signed [SW-1:0]  p_s;
  logic                  ent_lt;
  logic                  ent_gt;
  logic                  fetch_ok;
  logic [CW-1:0]         ptr_inc;

  op_kind_t              res_op;
  logic signed [SW-1:0]  res_idx;
  logic [STAT_W-1:0]     res_stat;
  logic [AW-1:0]         res_tgt;
  logic                  res_clr;
  logic signed [SW-1:0]  q_plus;
  logic                  full;

  // Both bounds are non-negative whenever a probe is taken.
  assign sum    = {s_r[SW-1], s_r} + {e_r[SW-1], e_r};
  assign p      = sum[AW:1];
  assign p_s    = SW'(p_r);
  assign ent_lt = $signed(rd_data_r) < $signed(key_r);
  assign ent_gt = $signed(rd_data_r) > $signed(key_r);
  assign q_plus = q_r + SW'(1);
  assign full   = (count_r == FULL_CNT);
  assign ptr_inc = CW'(ptr_r) + CW'(1);
  assign fetch_ok = !idx_r[SW-1] && (idx_r[CW-1:0] < count_r);

  always_comb begin
    stat.is_search = (cmd_r == CMD_SEARCH) || (cmd_r == CMD_INSERT) ||
                     (cmd_r == CMD_REMOVE);
    stat.srch_more = (s_r <= e_r);
    stat.srch_eq   = !ent_lt && !ent_gt;
    stat.op        = res_op;
    stat.up_more   = (ptr_r > t_r);
    stat.dn_more   = (ptr_inc < count_r);
    stat.out_busy  = out_valid_r && !out_tready;
  end

  // Outcome of the command once the search, if any, has finished.
  always_comb begin
    res_op   = OP_NONE;
    res_idx  = '1;
    res_stat = ST_DONE;
    res_tgt  = '0;
    res_clr  = 1'b0;
    case (cmd_r)
      CMD_SEARCH: begin
        res_idx  = q_r;
        res_stat = hit_r ? ST_DONE : ST_ABSENT;
      end
      CMD_INSERT: begin
        if (hit_r) begin
          res_idx  = q_r;
          res_stat = ST_ABSENT;
        end else if (full) begin
          res_stat = ST_FULL;
        end else begin
          res_idx = q_plus;
          res_op  = OP_INS;
          res_tgt = q_plus[AW-1:0];
        end
      end
      CMD_REMOVE: begin
        if (!hit_r) begin
          res_stat = ST_ABSENT;
        end else begin
          res_idx = q_r;
          res_op  = OP_DEL;
          res_tgt = q_r[AW-1:0];
        end
      end
      CMD_INS_AT: begin
        if (pos_r > count_r) begin
          res_stat = ST_BADPOS;
        end else if (full) begin
          res_stat = ST_FULL;
        end else begin
          res_idx = SW'(pos_r);
          res_op  = OP_INS;
          res_tgt = pos_r[AW-1:0];
        end
      end
      CMD_DEL_AT: begin
        if (pos_r >= count_r) begin
          res_stat = ST_BADPOS;
        end else begin
          res_idx = SW'(pos_r);
          res_op  = OP_DEL;
          res_tgt = pos_r[AW-1:0];
        end
      end
      CMD_CLEAR: begin
        res_clr = 1'b1;
      end
      default: begin
        res_op = OP_NONE;
      end
    endcase
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = ptr_r;
    wr_data = rd_data_r;
    if (cmd.srch_step && stat.srch_more) begin
      rd_en   = 1'b1;
      rd_addr = p;
    end
    if (cmd.up_step && stat.up_more) begin
      rd_en   = 1'b1;
      rd_addr = ptr_r - AW'(1);
    end
    if (cmd.dn_step && stat.dn_more) begin
      rd_en   = 1'b1;
      rd_addr = ptr_r + AW'(1);
    end
    if (cmd.fetch) begin
      rd_en   = 1'b1;
      rd_addr = idx_r[AW-1:0];
    end
    if (cmd.up_write || cmd.dn_write) begin
      wr_en = 1'b1;
    end
    if (cmd.put) begin
      wr_en   = 1'b1;
      wr_addr = t_r;
      wr_data = key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.resolve && res_clr) begin
        count_r <= '0;
      end else if (cmd.put) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.dn_step && !stat.dn_more) begin
        count_r <= count_r - CW'(1);
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_cmd;
      key_r <= in_key_value;
      pos_r <= in_position;
      s_r   <= '0;
      e_r   <= SW'(count_r) - SW'(1);
      q_r   <= '1;
      hit_r <= 1'b0;
    end
    if (cmd.srch_step && stat.srch_more) begin
      p_r <= p;
    end
    if (cmd.srch_cmp) begin
      if (ent_lt) begin
        s_r <= p_s + SW'(1);
        q_r <= p_s;
      end else if (ent_gt) begin
        e_r <= p_s - SW'(1);
        q_r <= p_s - SW'(1);
      end else begin
        hit_r <= 1'b1;
        q_r   <= p_s;
      end
    end
    if (cmd.resolve) begin
      idx_r  <= res_idx;
      stat_r <= res_stat;
      t_r    <= res_tgt;
      ptr_r  <= (res_op == OP_INS) ? count_r[AW-1:0] : res_tgt;
    end
    if (cmd.up_write) begin
      ptr_r <= ptr_r - AW'(1);
    end
    if (cmd.dn_write) begin
      ptr_r <= ptr_r + AW'(1);
    end
    if (cmd.fetch) begin
      fetch_ok_r <= fetch_ok;
    end
    if (cmd.finish) begin
      out_idx_r   <= idx_r[RW-1:0];
      out_stat_r  <= stat_r;
      out_entry_r <= fetch_ok_r ? rd_data_r : '0;
      out_fill_r  <= count_r;
    end
  end

  assign out_tvalid         = out_valid_r;
  assign out_result_index   = out_idx_r;
  assign out_status         = out_stat_r;
  assign out_entry_at_index = out_entry_r;
  assign out_fill_count     = out_fill_r;

endmodule

`default_nettype wire

### rtl/sorted_set_table.sv
// Top level of the sorted set table: stream ports, field packing, and the
// controller and datapath instances.
// Depends on sst_pkg, sst_ctrl and sst_dpath.
//
//   Channel  Ports                          Carries
//   in       in_tvalid/in_tready/in_tdata   one command request
//   out      out_tvalid/out_tready/out_tdata one result per request
//
// A request is decoded, binary searched if it is a value command (at most
// log2(DEPTH)+1 probes, each a read then a compare), resolved; an insert that
// changes the table moves entries up and puts the key, a removal moves them
// down; last the result is fetched and loaded. Probes and moves share one memory
// port. Reset clears the fill count and the controller; entries need no clearing.
// A stalled output holds its result; the next request is taken and then waits.
`default_nettype none

module sorted_set_table
  import sst_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  localparam int AW        = $clog2(DEPTH),
  localparam int CW        = $clog2(DEPTH + 1),
  localparam int RW        = AW + 1,
  localparam int IN_W      = ((CMD_W + VALUE_BITS + CW + 7) / 8) * 8,
  localparam int OUT_W     = ((RW + STAT_W + VALUE_BITS + CW + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // cmd, key_value, position, zero pad
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // result_index, status, entry_at_index,
                                       // fill_count, zero pad
);

  ctrl_cmd_t             cmd;
  dp_stat_t              stat;
  logic [CMD_W-1:0]      in_cmd;
  logic [VALUE_BITS-1:0] in_key_value;
  logic [CW-1:0]         in_position;
  logic [RW-1:0]         out_result_index;
  logic [STAT_W-1:0]     out_status;
  logic [VALUE_BITS-1:0] out_entry_at_index;
  logic [CW-1:0]         out_fill_count;

  assign in_cmd       = in_tdata[CMD_W-1:0];
  assign in_key_value = in_tdata[CMD_W +: VALUE_BITS];
  assign in_position  = in_tdata[CMD_W + VALUE_BITS +: CW];

  assign out_tdata = OUT_W'({out_fill_count, out_entry_at_index, out_status,
                             out_result_index});

  sst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sst_dpath #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_cmd             (in_cmd),
    .in_key_value       (in_key_value),
    .in_position        (in_position),
    .out_tready         (out_tready),
    .out_tvalid         (out_tvalid),
    .out_result_index   (out_result_index),
    .out_status         (out_status),
    .out_entry_at_index (out_entry_at_index),
    .out_fill_count     (out_fill_count)
  );

`ifndef ASSERT_OFF
  a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_status == ST_FULL) |-> out_fill_count == CW'(DEPTH))
    else $error("full status reported with spare room in the table");

  a_none_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_result_index == '1) |-> out_entry_at_index == '0)
    else $error("entry value given for a result without an index");

  a_index_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_result_index[RW-1]
      |-> CW'(out_result_index[AW-1:0]) <= out_fill_count)
    else $error("result index lies beyond the fill count");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while one is in progress");
`endif

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking bench for sorted_set_table: drives command requests on the input
// stream and checks every result against an in-bench model of the sorted table.
// Depends on sst_pkg and the sorted_set_table RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sst_pkg::*;

  localparam int KEY_W  = VALUE_BITS_DEF;
  localparam int POS_W  = 9;
  localparam int IDX_W  = 9;
  localparam int IN_W   = ((CMD_W + KEY_W + POS_W + 7) / 8) * 8;
  localparam int OUT_W  = ((IDX_W + STAT_W + KEY_W + POS_W + 7) / 8) * 8;
  localparam int SLOTS  = DEPTH_DEF;

  // Command codes the block decodes as no-ops.
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [STAT_W-1:0] status;
    logic [KEY_W-1:0]  entry;
    logic [POS_W-1:0]  fill;
  } table_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;   // cmd, key_value, position, zero pad
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;       // result_index, status, entry_at_index,
                                     // fill_count, zero pad

  // Model of the table contents as seen after each accepted request.
  int set_vals [SLOTS];
  int set_fill = 0;

  table_result_t pending_results[$];
  int            mismatch_count = 0;

  // Sender and receiver pacing controls.
  int burst_left = 0;
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;
  bit hold_req = 1'b0;

  sorted_set_table DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Binary floor search, probe for probe as the table walks it, so that a table
  // made unordered by positional inserts still gives the same answer.
  function automatic int floor_index(input int key, output bit exact);
    int q;
    int s;
    int e;
    int p;
    q = -1;
    s = 0;
    e = set_fill - 1;
    exact = 1'b0;
    while (s <= e) begin
      p = (s + e) / 2;
      if (set_vals[p] < key) begin
        s = p + 1;
        q = p;
      end else if (set_vals[p] > key) begin
        e = p - 1;
        q = e;
      end else begin
        exact = 1'b1;
        return p;
      end
    end
    return q;
  endfunction

  function automatic void open_slot(input int pos, input int key);
    for (int i = set_fill; i > pos; i--) set_vals[i] = set_vals[i-1];
    set_vals[pos] = key;
    set_fill++;
  endfunction

  function automatic void close_slot(input int pos);
    for (int i = pos; i + 1 < set_fill; i++) set_vals[i] = set_vals[i+1];
    set_fill--;
  endfunction

  // Applies one request to the model table and returns the result it must give.
  function automatic table_result_t apply_request(input logic [CMD_W-1:0] op,
                                                  input int key, input int pos);
    table_result_t r;
    int idx;
    bit exact;
    idx = -1;
    r = '0;
    r.status = ST_DONE;
    case (op)
      CMD_SEARCH: begin
        idx = floor_index(key, exact);
        r.status = exact ? ST_DONE : ST_ABSENT;
      end
      CMD_INSERT: begin
        idx = floor_index(key, exact);
        if (exact) begin
          r.status = ST_ABSENT;
        end else if (set_fill >= SLOTS) begin
          idx = -1;
          r.status = ST_FULL;
        end else begin
          idx = idx + 1;
          open_slot(idx, key);
        end
      end
      CMD_REMOVE: begin
        idx = floor_index(key, exact);
        if (!exact) begin
          idx = -1;
          r.status = ST_ABSENT;
        end else begin
          close_slot(idx);
        end
      end
      CMD_INS_AT: begin
        if (pos > set_fill) begin
          r.status = ST_BADPOS;
        end else if (set_fill >= SLOTS) begin
          r.status = ST_FULL;
        end else begin
          open_slot(pos, key);
          idx = pos;
        end
      end
      CMD_DEL_AT: begin
        if (pos >= set_fill) begin
          r.status = ST_BADPOS;
        end else begin
          close_slot(pos);
          idx = pos;
        end
      end
      CMD_CLEAR: begin
        set_fill = 0;
      end
      default: begin
      end
    endcase
    r.idx  = idx[IDX_W-1:0];
    r.fill = set_fill[POS_W-1:0];
    if (idx >= 0 && idx < set_fill) r.entry = set_vals[idx];
    return r;
  endfunction

  // Offers one request, pausing between bursts, and records its expected result
  // at the edge where it is accepted.
  task automatic send_request(input logic [CMD_W-1:0] op, input int key, input int pos);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if (gaps_on) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_W - CMD_W - KEY_W - POS_W){1'b0}}, pos[POS_W-1:0], key, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.insert(pending_results.size(), apply_request(op, key, pos));
  endtask

  // Receiver: ready runs and short stalls, or one long hold-off on request.
  initial begin
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  task automatic report_field(input string name, input logic [KEY_W-1:0] want,
                              input logic [KEY_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $realtime, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    table_result_t want;
    table_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.idx    = out_tdata[IDX_W-1:0];
      got.status = out_tdata[IDX_W +: STAT_W];
      got.entry  = out_tdata[IDX_W + STAT_W +: KEY_W];
      got.fill   = out_tdata[IDX_W + STAT_W + KEY_W +: POS_W];
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual 0x%0h", $realtime, got);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        report_field("result_index", want.idx, got.idx);
        report_field("status", want.status, got.status);
        report_field("entry_at_index", want.entry, got.entry);
        report_field("fill_count", want.fill, got.fill);
      end
    end
  end

  // Empty-table corner cases, extreme keys, every command and the out-of-order
  // positional insert.
  task automatic test_directed();
    send_request(CMD_SEARCH, 0, 0);
    send_request(CMD_REMOVE, 5, 0);
    send_request(CMD_DEL_AT, 0, 0);
    send_request(CMD_INS_AT, 7, 1);
    send_request(CMD_INS_AT, 7, 256);
    send_request(CMD_INSERT, 0, 0);
    send_request(CMD_INSERT, 32'h7fff_ffff, 0);
    send_request(CMD_INSERT, 32'h8000_0000, 511);
    send_request(CMD_INSERT, 0, 0);
    send_request(CMD_SEARCH, -1, 0);
    send_request(CMD_SEARCH, 32'h8000_0000, 0);
    send_request(CMD_SEARCH, 5, 0);
    send_request(CMD_SEARCH, 32'h7fff_ffff, 0);
    send_request(CMD_INS_AT, 1000, 1);
    send_request(CMD_SEARCH, 0, 0);
    send_request(CMD_INS_AT, -1, 4);
    send_request(CMD_DEL_AT, 0, 4);
    send_request(CMD_DEL_AT, 0, 0);
    send_request(CMD_REMOVE, 1000, 0);
    send_request(CMD_REMOVE, 1000, 0);
    send_request(CMD_SPARE_A, $urandom, $urandom_range(0, 256));
    send_request(CMD_SPARE_B, $urandom, $urandom_range(0, 256));
    send_request(CMD_CLEAR, 32'h5555_aaaa, 0);
    send_request(CMD_SEARCH, 32'h7fff_ffff, 0);
    send_request(CMD_INSERT, -1, 0);
  endtask

  // Fills every slot, then works the full-table cases and the longest shifts.
  task automatic test_full_table();
    send_request(CMD_CLEAR, 0, 0);
    for (int i = 0; i < SLOTS; i++) send_request(CMD_INSERT, i * 8191 - 1000000, 0);
    send_request(CMD_INSERT, 3, 0);
    send_request(CMD_INSERT, 100 * 8191 - 1000000, 0);
    send_request(CMD_INS_AT, 3, 256);
    send_request(CMD_INS_AT, 3, 0);
    send_request(CMD_SEARCH, 32'h8000_0000, 0);
    send_request(CMD_SEARCH, 32'h7fff_ffff, 0);
    send_request(CMD_SEARCH, 37 * 8191 - 1000000, 0);
    send_request(CMD_DEL_AT, 0, 256);
    send_request(CMD_DEL_AT, 0, 255);
    send_request(CMD_INS_AT, 32'h7fff_ffff, 255);
    send_request(CMD_DEL_AT, 0, 0);
    send_request(CMD_INS_AT, 32'h8000_0000, 0);
    send_request(CMD_REMOVE, 128 * 8191 - 1000000, 0);
    send_request(CMD_INSERT, 128 * 8191 - 1000000, 0);
    send_request(CMD_CLEAR, 0, 0);
  endtask

  // The receiver holds off while requests keep coming, so the block backs up.
  task automatic test_backpressure();
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 16; i++) begin
      send_request((i % 3 == 0) ? CMD_SEARCH : CMD_INSERT, $urandom_range(0, 40) - 20, 0);
    end
    gaps_on = 1'b1;
  endtask

  function automatic int pick_key(input int base, input int span);
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 2)
                                     : 32'h8000_0000 + $urandom_range(0, 2);
      2: return (set_fill > 0) ? set_vals[$urandom_range(0, set_fill - 1)] : base;
      default: return base + int'($urandom_range(0, span));
    endcase
  endfunction

  // Random command mix over tables kept mostly small, with the pacing and the
  // key neighborhood changed every segment.
  task automatic test_random_mix(input int n_items);
    int cap;
    int base;
    int span;
    int r;
    int key;
    int pos;
    logic [CMD_W-1:0] op;
    for (int n = 0; n < n_items; n++) begin
      if (n % 100 == 0) begin
        cap = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 160) : $urandom_range(2, 32);
        gaps_on   = $urandom_range(0, 3) != 0;
        stalls_on = $urandom_range(0, 3) != 0;
        base = $urandom;
        span = $urandom_range(8, 200);
      end
      r = $urandom_range(0, 99);
      if (set_fill >= cap) begin
        op = (r < 10) ? CMD_CLEAR : (r < 55) ? CMD_REMOVE : CMD_DEL_AT;
      end else if (r < 28) begin
        op = CMD_SEARCH;
      end else if (r < 55) begin
        op = CMD_INSERT;
      end else if (r < 70) begin
        op = CMD_REMOVE;
      end else if (r < 82) begin
        op = CMD_INS_AT;
      end else if (r < 94) begin
        op = CMD_DEL_AT;
      end else if (r < 97) begin
        op = CMD_CLEAR;
      end else begin
        op = (r == 97) ? CMD_SPARE_A : CMD_SPARE_B;
      end
      key = pick_key(base, span);
      if ((op == CMD_REMOVE || op == CMD_SEARCH) && set_fill > 0 && $urandom_range(0, 1))
        key = set_vals[$urandom_range(0, set_fill - 1)];
      pos = $urandom_range(0, 256);
      if (op == CMD_INS_AT && $urandom_range(0, 7) != 0) pos = $urandom_range(0, set_fill);
      if (op == CMD_DEL_AT && set_fill > 0 && $urandom_range(0, 7) != 0)
        pos = $urandom_range(0, set_fill - 1);
      send_request(op, key, pos);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_table();
    test_backpressure();
    test_random_mix(1400);
    in_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (600) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** sorted_set_table: PASSED **");
    end else begin
      $display("** sorted_set_table: FAILED **");
    end
    $finish;
  end

  // Generous cap: the slowest legal run stays well under this.
  initial begin
    #(50_000_000);
    $display("** sorted_set_table: FAILED **");
    $finish;
  end

endmodule
